@@ design/edct_pkg.sv @@
// Shared types and constants of the event descriptor countdown table.
// Used by edct_front, edct_back and event_descriptor_countdown_table; no dependencies.
`default_nettype none

package edct_pkg;

	// Table geometry and stored field widths.
	localparam int NUM_EVENTS   = 64;
	localparam int COUNTER_BITS = 16;
	localparam int TASK_BITS    = 8;
	localparam int TBL_AW       = $clog2(NUM_EVENTS);

	// Widths of the word fields at the ports.
	localparam int IDX_BITS    = 6;
	localparam int RELOAD_BITS = 16;
	localparam int MASK_BITS   = 4;
	localparam int SEM_BITS    = 8;
	localparam int TSET_BITS   = 8;

	// Bit positions inside the action mask.
	localparam int MASK_SIGNAL  = 0;
	localparam int MASK_ENNEXT  = 2;
	localparam int MASK_RELEASE = 3;

	// Depths of the command queue and the result queue.
	localparam int FQ_DEPTH = 2;
	localparam int OQ_DEPTH = 2;

	typedef enum logic [1:0] {
		ACT_PROCESS = 2'd0,
		ACT_LOAD    = 2'd1,
		ACT_ENABLE  = 2'd2,
		ACT_DISABLE = 2'd3
	} act_t;

	typedef struct packed {
		logic [1:0]             action;
		logic [IDX_BITS-1:0]    event_index;
		logic [RELOAD_BITS-1:0] reload_value;
		logic                   single_shot;
		logic [MASK_BITS-1:0]   action_mask;
		logic [SEM_BITS-1:0]    semaphore_id;
		logic [TSET_BITS-1:0]   task_set;
		logic [IDX_BITS-1:0]    follower_index;
		logic                   start_enabled;
		logic                   sweep_end;
	} edct_in_t;

	typedef struct packed {
		logic [IDX_BITS-1:0]  event_id;
		logic                 fired;
		logic                 do_signal;
		logic                 do_release;
		logic [SEM_BITS-1:0]  signal_target;
		logic [TSET_BITS-1:0] release_tasks;
		logic                 sweep_done;
	} edct_out_t;

	// One stored descriptor; the follower is kept already range checked.
	typedef struct packed {
		logic                    one_off;
		logic [COUNTER_BITS-1:0] count;
		logic [COUNTER_BITS-1:0] reload;
		logic [MASK_BITS-1:0]    mask;
		logic [SEM_BITS-1:0]     sem;
		logic [TASK_BITS-1:0]    tasks;
		logic                    fol_ok;
		logic [TBL_AW-1:0]       follower;
	} desc_t;

	// Classified command handed from the front to the back.
	typedef struct packed {
		act_t                    op;
		logic                    in_range;
		logic [TBL_AW-1:0]       addr;
		logic [IDX_BITS-1:0]     event_id;
		logic [COUNTER_BITS-1:0] reload;
		logic                    one_off;
		logic [MASK_BITS-1:0]    mask;
		logic [SEM_BITS-1:0]     sem;
		logic [TASK_BITS-1:0]    tasks;
		logic                    fol_ok;
		logic [TBL_AW-1:0]       follower;
		logic                    start_en;
		logic                    sweep_end;
	} cmd_t;

	// Handshake between the command queue and the table engine.
	typedef struct packed {
		logic valid;
	} cmd_stat_t;

endpackage

`default_nettype wire

@@ design/edct_front.sv @@
// Front part: accepts input words, classifies them and queues commands.
// Depends on edct_pkg.
`default_nettype none

module edct_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire edct_pkg::edct_in_t item,
	output edct_pkg::cmd_stat_t   stat,
	input  wire logic             cmd_take,
	output edct_pkg::cmd_t        cmd
);

	localparam int FQ_AW = (edct_pkg::FQ_DEPTH > 1) ? $clog2(edct_pkg::FQ_DEPTH) : 1;
	localparam int FQ_CW = $clog2(edct_pkg::FQ_DEPTH + 1);

	edct_pkg::cmd_t fq_q [edct_pkg::FQ_DEPTH];
	logic [FQ_AW-1:0] wr_q;
	logic [FQ_AW-1:0] rd_q;
	logic [FQ_CW-1:0] cnt_q;
	edct_pkg::cmd_t   cls;
	logic             do_push;
	logic             do_pop;

	// Range checks are made once here so the back sees clean table addresses.
	always_comb begin
		cls.op        = edct_pkg::act_t'(item.action);
		cls.in_range  = {1'b0, item.event_index} < (edct_pkg::IDX_BITS + 1)'(edct_pkg::NUM_EVENTS);
		cls.addr      = item.event_index[edct_pkg::TBL_AW-1:0];
		cls.event_id  = item.event_index;
		cls.reload    = edct_pkg::COUNTER_BITS'(item.reload_value);
		cls.one_off   = item.single_shot;
		cls.mask      = item.action_mask;
		cls.sem       = item.semaphore_id;
		cls.tasks     = edct_pkg::TASK_BITS'(item.task_set);
		cls.fol_ok    = {1'b0, item.follower_index}
			< (edct_pkg::IDX_BITS + 1)'(edct_pkg::NUM_EVENTS);
		cls.follower  = item.follower_index[edct_pkg::TBL_AW-1:0];
		cls.start_en  = item.start_enabled;
		cls.sweep_end = item.sweep_end;
	end

	assign full       = (cnt_q == FQ_CW'(edct_pkg::FQ_DEPTH));
	assign stat.valid = (cnt_q != '0);
	assign cmd        = fq_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = cmd_take && stat.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			fq_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == FQ_AW'(edct_pkg::FQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == FQ_AW'(edct_pkg::FQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ design/edct_back.sv @@
// Back part: descriptor memory, enable flags, countdown engine and result queue.
// Depends on edct_pkg.
`default_nettype none

module edct_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire edct_pkg::cmd_stat_t stat,
	output logic                     cmd_take,
	input  wire edct_pkg::cmd_t      cmd,
	output logic                     empty,
	input  wire logic                pop,
	output edct_pkg::edct_out_t      result
);

	localparam int OQ_AW = (edct_pkg::OQ_DEPTH > 1) ? $clog2(edct_pkg::OQ_DEPTH) : 1;
	localparam int OQ_CW = $clog2(edct_pkg::OQ_DEPTH + 1);

	typedef enum logic {ST_IDLE, ST_EXEC} state_t;

	state_t state_q;

	edct_pkg::desc_t mem [edct_pkg::NUM_EVENTS];
	edct_pkg::desc_t rdata_q;
	edct_pkg::cmd_t  item_s1;

	logic [edct_pkg::NUM_EVENTS-1:0] en_q;
	logic [edct_pkg::NUM_EVENTS-1:0] en_d;

	edct_pkg::edct_out_t oq_q [edct_pkg::OQ_DEPTH];
	logic [OQ_AW-1:0] oq_wr_q;
	logic [OQ_AW-1:0] oq_rd_q;
	logic [OQ_CW-1:0] oq_cnt_q;

	logic                    start;
	logic                    exec;
	logic                    oq_pop;
	logic                    wr_en;
	edct_pkg::desc_t         wr_data;
	logic                    set_fol;
	logic                    clr_self;
	logic                    fire;
	logic [edct_pkg::COUNTER_BITS-1:0] cnt_dec;
	edct_pkg::edct_out_t     res;

	// A command starts only when the result queue has room for its word.
	assign start    = (state_q == ST_IDLE) && stat.valid
		&& (oq_cnt_q < OQ_CW'(edct_pkg::OQ_DEPTH));
	assign cmd_take = start;
	assign exec     = (state_q == ST_EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (start) state_q <= ST_EXEC;
				ST_EXEC: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			item_s1 <= cmd;
			rdata_q <= mem[cmd.addr];
		end
		if (wr_en) begin
			mem[item_s1.addr] <= wr_data;
		end
	end

	always_comb begin
		cnt_dec  = rdata_q.count - edct_pkg::COUNTER_BITS'(1);
		fire     = 1'b0;
		wr_en    = 1'b0;
		wr_data  = rdata_q;
		set_fol  = 1'b0;
		clr_self = 1'b0;
		if (exec && item_s1.in_range) begin
			case (item_s1.op)
				edct_pkg::ACT_PROCESS: begin
					if (en_q[item_s1.addr]) begin
						wr_en = 1'b1;
						if (cnt_dec == '0) begin
							fire          = 1'b1;
							wr_data.count = rdata_q.reload;
							set_fol       = rdata_q.mask[edct_pkg::MASK_ENNEXT] && rdata_q.fol_ok;
							clr_self      = rdata_q.one_off;
						end else begin
							wr_data.count = cnt_dec;
						end
					end
				end
				edct_pkg::ACT_LOAD: begin
					wr_en            = 1'b1;
					wr_data.one_off  = item_s1.one_off;
					wr_data.count    = item_s1.reload;
					wr_data.reload   = item_s1.reload;
					wr_data.mask     = item_s1.mask;
					wr_data.sem      = item_s1.sem;
					wr_data.tasks    = item_s1.tasks;
					wr_data.fol_ok   = item_s1.fol_ok;
					wr_data.follower = item_s1.follower;
				end
				default: begin
				end
			endcase
		end

		res.event_id      = item_s1.event_id;
		res.fired         = fire;
		res.do_signal     = fire && rdata_q.mask[edct_pkg::MASK_SIGNAL];
		res.do_release    = fire && rdata_q.mask[edct_pkg::MASK_RELEASE];
		res.signal_target = fire ? rdata_q.sem : '0;
		res.release_tasks = fire ? edct_pkg::TSET_BITS'(rdata_q.tasks) : '0;
		res.sweep_done    = item_s1.sweep_end;
	end

	// The self-disable of a one-off entry is applied last so it wins over enable-next.
	always_comb begin
		en_d = en_q;
		if (exec && item_s1.in_range) begin
			case (item_s1.op)
				edct_pkg::ACT_PROCESS: begin
					if (set_fol) en_d[rdata_q.follower] = 1'b1;
					if (clr_self) en_d[item_s1.addr] = 1'b0;
				end
				edct_pkg::ACT_LOAD:    en_d[item_s1.addr] = item_s1.start_en;
				edct_pkg::ACT_ENABLE:  en_d[item_s1.addr] = 1'b1;
				edct_pkg::ACT_DISABLE: en_d[item_s1.addr] = 1'b0;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= '0;
		end else begin
			en_q <= en_d;
		end
	end

	assign empty  = (oq_cnt_q == '0);
	assign result = oq_q[oq_rd_q];
	assign oq_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (exec) begin
			oq_q[oq_wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (exec) begin
				oq_wr_q <= (oq_wr_q == OQ_AW'(edct_pkg::OQ_DEPTH - 1)) ? '0 : oq_wr_q + 1'b1;
			end
			if (oq_pop) begin
				oq_rd_q <= (oq_rd_q == OQ_AW'(edct_pkg::OQ_DEPTH - 1)) ? '0 : oq_rd_q + 1'b1;
			end
			case ({exec, oq_pop})
				2'b10:   oq_cnt_q <= oq_cnt_q + 1'b1;
				2'b01:   oq_cnt_q <= oq_cnt_q - 1'b1;
				default: oq_cnt_q <= oq_cnt_q;
			endcase
		end
	end

	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		oq_cnt_q <= OQ_CW'(edct_pkg::OQ_DEPTH))
		else $error("result queue overfilled");

	a_exec_one: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> (state_q == ST_IDLE))
		else $error("execute phase lasted more than one cycle");

	a_start_room: assert property (@(posedge clk) disable iff (!arst_n)
		exec |-> (oq_cnt_q < OQ_CW'(edct_pkg::OQ_DEPTH)) || oq_pop)
		else $error("result pushed into a full queue");

	a_fire_process: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> (item_s1.op == edct_pkg::ACT_PROCESS) && item_s1.in_range)
		else $error("fire on a non-process command");

endmodule

`default_nettype wire

@@ design/event_descriptor_countdown_table.sv @@
// Top level of the event descriptor countdown table.
// Depends on edct_pkg, edct_front and edct_back.
//
// Usage: input words are written like into a queue: a word is taken at a
// rising edge with push high and full low. Each word loads, enables,
// disables or processes one table entry. Every input word yields exactly one
// result word, read like from a queue: the oldest result is on the result
// port while empty is low and is taken at an edge with pop high.
// A taken word goes through the command queue, the read of its descriptor
// and the update and write back, at which its result is queued. The
// back takes no new word before the last is written back, as set by the
// read-modify-write of the single-port descriptor memory (read, then update and write back).
// Reset clears all enable flags and empties both queues; descriptor contents
// stay undefined until loaded, so no clearing pass is needed.
// full rises whenever the command queue (two words) is full. Back-to-back
// input does that too, since the back takes no new word while it executes one.
// When the receiver stalls, the result queue (two words) fills first and
// then the command queue, so four words are held before full stays high.
`default_nettype none

module event_descriptor_countdown_table (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire edct_pkg::edct_in_t  item,
	output logic                     empty,
	input  wire logic                pop,
	output edct_pkg::edct_out_t      result
);

	edct_pkg::cmd_stat_t stat;
	edct_pkg::cmd_t      cmd;
	logic                cmd_take;

	// The front decouples the input side from the table engine.
	edct_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.stat     (stat),
		.cmd_take (cmd_take),
		.cmd      (cmd)
	);

	// The back owns the table and holds finished results until popped.
	edct_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.cmd_take (cmd_take),
		.cmd      (cmd),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking testbench for event_descriptor_countdown_table.
// Depends on edct_pkg and the RTL of the block; holds its own prediction of
// the descriptor table and checks every result word against it.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Stop after this many input words (directed part included).
	localparam int WORD_TARGET = 1250;
	// Cycles without any accepted word, in either direction, that count as a hang.
	localparam int HANG_LIMIT = 4000;
	// Cycles to keep watching after the last expected result has come.
	localparam int TAIL_CYCLES = 16;

	// The scoreboard keeps a copy of the descriptor table. Each accepted input
	// word updates that copy and queues the result word it must produce; each
	// accepted result word is checked against the oldest queued one.
	class countdown_scoreboard;
		bit                                enabled [edct_pkg::NUM_EVENTS];
		bit                                loaded [edct_pkg::NUM_EVENTS];
		bit                                one_off [edct_pkg::NUM_EVENTS];
		logic [edct_pkg::COUNTER_BITS-1:0] count [edct_pkg::NUM_EVENTS];
		logic [edct_pkg::COUNTER_BITS-1:0] reload [edct_pkg::NUM_EVENTS];
		logic [edct_pkg::MASK_BITS-1:0]    mask [edct_pkg::NUM_EVENTS];
		logic [edct_pkg::SEM_BITS-1:0]     sem [edct_pkg::NUM_EVENTS];
		logic [edct_pkg::TASK_BITS-1:0]    tasks [edct_pkg::NUM_EVENTS];
		logic [edct_pkg::IDX_BITS-1:0]     follower [edct_pkg::NUM_EVENTS];
		edct_pkg::edct_out_t               due_results [$];
		int unsigned                       errors;

		function new();
			foreach (enabled[i]) begin
				enabled[i] = 1'b0;
				loaded[i] = 1'b0;
			end
			errors = 0;
		endfunction

		// An entry that is enabled but was never loaded holds undefined
		// contents, so it must not be ticked.
		function bit may_process(int idx);
			return loaded[idx] || !enabled[idx];
		endfunction

		function void take_word(edct_pkg::edct_in_t w);
			edct_pkg::edct_out_t               r;
			int                                idx;
			logic [edct_pkg::COUNTER_BITS-1:0] next_count;
			r = '0;
			idx = w.event_index;
			r.event_id = w.event_index;
			r.sweep_done = w.sweep_end;
			if (idx < edct_pkg::NUM_EVENTS) begin
				case (edct_pkg::act_t'(w.action))
				edct_pkg::ACT_PROCESS: begin
					if (enabled[idx]) begin
						next_count = count[idx] - 1'b1;
						count[idx] = next_count;
						if (next_count == '0) begin
							r.fired = 1'b1;
							r.signal_target = sem[idx];
							r.release_tasks = tasks[idx];
							r.do_signal = mask[idx][edct_pkg::MASK_SIGNAL];
							r.do_release = mask[idx][edct_pkg::MASK_RELEASE];
							if (mask[idx][edct_pkg::MASK_ENNEXT]
								&& follower[idx] < edct_pkg::NUM_EVENTS)
								enabled[follower[idx]] = 1'b1;
							count[idx] = reload[idx];
							// Self-disable comes after enable-next, so it wins
							// when the follower is the entry itself.
							if (one_off[idx])
								enabled[idx] = 1'b0;
						end
					end
				end
				edct_pkg::ACT_LOAD: begin
					reload[idx] = w.reload_value[edct_pkg::COUNTER_BITS-1:0];
					count[idx] = w.reload_value[edct_pkg::COUNTER_BITS-1:0];
					one_off[idx] = w.single_shot;
					mask[idx] = w.action_mask;
					sem[idx] = w.semaphore_id;
					tasks[idx] = w.task_set[edct_pkg::TASK_BITS-1:0];
					follower[idx] = w.follower_index;
					enabled[idx] = w.start_enabled;
					loaded[idx] = 1'b1;
				end
				edct_pkg::ACT_ENABLE: begin
					enabled[idx] = 1'b1;
				end
				edct_pkg::ACT_DISABLE: begin
					enabled[idx] = 1'b0;
				end
				default: begin
				end
				endcase
			end
			due_results.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_result(edct_pkg::edct_out_t got);
			edct_pkg::edct_out_t want;
			if (due_results.size() == 0) begin
				errors++;
				$display("%0t: result word with none expected, actual %h", $time, got);
				return;
			end
			want = due_results.pop_front();
			compare_field("event_id", want.event_id, got.event_id);
			compare_field("fired", want.fired, got.fired);
			compare_field("do_signal", want.do_signal, got.do_signal);
			compare_field("do_release", want.do_release, got.do_release);
			compare_field("signal_target", want.signal_target, got.signal_target);
			compare_field("release_tasks", want.release_tasks, got.release_tasks);
			compare_field("sweep_done", want.sweep_done, got.sweep_done);
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                push = 1'b0;
	logic                pop = 1'b0;
	logic                full;
	logic                empty;
	edct_pkg::edct_in_t  item = '0;
	edct_pkg::edct_out_t result;

	countdown_scoreboard board = new();

	// Sender burst bookkeeping and the count of accepted input words.
	int burst_left = 0;
	int words_sent = 0;

	event_descriptor_countdown_table uut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	// 8 ns clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Fully random word: every field, including the unused ones, takes any value.
	function automatic edct_pkg::edct_in_t random_word();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(edct_pkg::edct_in_t)-1:0];
	endfunction

	function automatic edct_pkg::edct_in_t op_word(edct_pkg::act_t op, int idx, bit last);
		edct_pkg::edct_in_t w;
		w = random_word();
		w.action = op;
		w.event_index = edct_pkg::IDX_BITS'(idx);
		w.sweep_end = last;
		return w;
	endfunction

	function automatic edct_pkg::edct_in_t load_word(int idx, int rel, bit once, int msk,
		int sid, int tset, int fol, bit en);
		edct_pkg::edct_in_t w;
		w = op_word(edct_pkg::ACT_LOAD, idx, 1'b0);
		w.reload_value = edct_pkg::RELOAD_BITS'(rel);
		w.single_shot = once;
		w.action_mask = edct_pkg::MASK_BITS'(msk);
		w.semaphore_id = edct_pkg::SEM_BITS'(sid);
		w.task_set = edct_pkg::TSET_BITS'(tset);
		w.follower_index = edct_pkg::IDX_BITS'(fol);
		w.start_enabled = en;
		return w;
	endfunction

	// Drives one word and returns at the edge where it is taken. The sender
	// works in bursts; a new burst starts after a random gap, which may be
	// empty. push is only lowered when the gap really has cycles in it, so it
	// never gets two assignments in one step.
	task automatic send_word(edct_pkg::edct_in_t w);
		int gap;
		if (w.action == edct_pkg::ACT_PROCESS && !board.may_process(w.event_index))
			w.action = edct_pkg::ACT_DISABLE;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		push <= 1'b1;
		item <= w;
		do
			@(posedge clk);
		while (full);
		board.take_word(w);
		burst_left--;
		words_sent++;
	endtask

	// Holds the sender off until every expected result has been read out.
	task automatic drain_pause();
		push <= 1'b0;
		do
			@(posedge clk);
		while (board.due_results.size() != 0);
		burst_left = 0;
	endtask

	// A well-formed piece of work: (re)load a short run of entries, then sweep
	// over them a few times with process words, marking the last of each sweep.
	// Small thresholds keep the entries firing often; now and then a full-range
	// threshold or a zero threshold is loaded instead.
	task automatic run_sweep_sequence();
		int                 base;
		int                 n;
		int                 passes;
		int                 idx;
		int                 pick;
		edct_pkg::edct_in_t w;
		base = $urandom_range(0, edct_pkg::NUM_EVENTS - 1);
		n = $urandom_range(1, 8);
		for (int k = 0; k < n; k++) begin
			idx = (base + k) % edct_pkg::NUM_EVENTS;
			if (!board.loaded[idx] || $urandom_range(0, 2) == 0) begin
				w = op_word(edct_pkg::ACT_LOAD, idx, 1'($urandom_range(0, 1)));
				pick = $urandom_range(0, 9);
				if (pick < 7)
					w.reload_value = edct_pkg::RELOAD_BITS'($urandom_range(1, 4));
				else if (pick == 7)
					w.reload_value = '0;
				w.single_shot = ($urandom_range(0, 2) == 0);
				if ($urandom_range(0, 9) < 7)
					w.follower_index = edct_pkg::IDX_BITS'(
						(base + $urandom_range(0, n - 1)) % edct_pkg::NUM_EVENTS);
				w.start_enabled = ($urandom_range(0, 4) != 0);
				send_word(w);
			end
		end
		passes = $urandom_range(1, 5);
		for (int p = 0; p < passes; p++)
			for (int k = 0; k < n; k++)
				send_word(op_word(edct_pkg::ACT_PROCESS, (base + k) % edct_pkg::NUM_EVENTS,
					k == n - 1));
	endtask

	// Result side: checks each word taken and stalls on a pattern of its own.
	// The pattern is redrawn periodically from always ready, a coin flip,
	// ready with a chance of one in four, and long stalls broken by short bursts.
	int rx_mode = 0;
	int rx_phase = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty)
				board.check_result(result);
			rx_phase++;
			if (rx_phase % 64 == 0)
				rx_mode = $urandom_range(0, 3);
			case (rx_mode)
			0: pop <= 1'b1;
			1: pop <= 1'($urandom_range(0, 1));
			2: pop <= ($urandom_range(0, 3) == 0);
			default: pop <= (rx_phase % 24) < 4;
			endcase
		end
	end

	// Hang detection: no word taken on either side for too long ends the run.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("FAIL event_descriptor_countdown_table");
			$finish;
		end
	end

	initial begin
		int choice;
		// Reset is held low from the start and released on a rising edge.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A never-loaded, disabled entry is ticked first; an
		// unloaded entry is enabled and disabled again without being ticked.
		send_word(op_word(edct_pkg::ACT_PROCESS, 0, 1'b0));
		send_word(op_word(edct_pkg::ACT_ENABLE, 63, 1'b0));
		send_word(op_word(edct_pkg::ACT_DISABLE, 63, 1'b1));
		// Entry 0 fires on every tick with every action, and enables entry 1.
		send_word(load_word(0, 1, 1'b0, 4'hF, 8'hFF, 8'hFF, 1, 1'b1));
		send_word(load_word(1, 2, 1'b1, 4'h0, 8'h00, 8'h00, 0, 1'b0));
		send_word(op_word(edct_pkg::ACT_PROCESS, 0, 1'b1));
		// Entry 1 is a one-off: it counts down, fires once and drops out.
		send_word(op_word(edct_pkg::ACT_PROCESS, 1, 1'b0));
		send_word(op_word(edct_pkg::ACT_PROCESS, 1, 1'b0));
		send_word(op_word(edct_pkg::ACT_PROCESS, 1, 1'b1));
		// A one-off entry whose follower is itself ends up disabled.
		send_word(load_word(2, 1, 1'b1, 4'h4, 8'h3C, 8'hC3, 2, 1'b1));
		send_word(op_word(edct_pkg::ACT_PROCESS, 2, 1'b0));
		send_word(op_word(edct_pkg::ACT_PROCESS, 2, 1'b1));
		// Zero threshold: the counter wraps to all ones instead of firing.
		send_word(load_word(3, 0, 1'b0, 4'hF, 8'h81, 8'h18, 0, 1'b1));
		send_word(op_word(edct_pkg::ACT_PROCESS, 3, 1'b0));
		send_word(op_word(edct_pkg::ACT_PROCESS, 3, 1'b1));
		// Largest threshold, alternating mask bits, last follower.
		send_word(load_word(4, 16'hFFFF, 1'b0, 4'hA, 8'h5A, 8'hA5, 63, 1'b1));
		send_word(op_word(edct_pkg::ACT_PROCESS, 4, 1'b0));
		// Mask bit 1 alone, which no action uses, fires without a signal or release.
		send_word(load_word(5, 1, 1'b0, 4'h2, 8'h01, 8'h80, 6, 1'b1));
		send_word(op_word(edct_pkg::ACT_PROCESS, 5, 1'b1));
		// Re-enable the one-off entry, and tick a disabled entry.
		send_word(op_word(edct_pkg::ACT_ENABLE, 1, 1'b0));
		send_word(op_word(edct_pkg::ACT_PROCESS, 1, 1'b0));
		send_word(op_word(edct_pkg::ACT_DISABLE, 0, 1'b0));
		send_word(op_word(edct_pkg::ACT_PROCESS, 0, 1'b1));
		// Release without signal on the next to last entry.
		send_word(load_word(62, 1, 1'b1, 4'h8, 8'h7F, 8'h7E, 63, 1'b1));
		send_word(op_word(edct_pkg::ACT_PROCESS, 62, 1'b1));
		drain_pause();

		// Random part: mostly load-and-sweep sequences, the rest enable and
		// disable words and fully random words.
		while (words_sent < WORD_TARGET) begin
			choice = $urandom_range(0, 9);
			if (choice < 6)
				run_sweep_sequence();
			else if (choice < 8)
				send_word(op_word($urandom_range(0, 1) ? edct_pkg::ACT_ENABLE
					: edct_pkg::ACT_DISABLE,
					$urandom_range(0, edct_pkg::NUM_EVENTS - 1), 1'($urandom_range(0, 1))));
			else
				send_word(random_word());
			if ($urandom_range(0, 59) == 0)
				drain_pause();
		end

		// Wind down: wait for the last results, then watch a little longer for
		// stray words.
		drain_pause();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.due_results.size() == 0)
			$display("PASS event_descriptor_countdown_table");
		else
			$display("FAIL event_descriptor_countdown_table");
		$finish;
	end

endmodule

`default_nettype wire
